/* sv/pcar_pkg.sv */
// Shared types and fixed field widths of the page cache age replacement unit.
`default_nettype none

package pcar_pkg;

    localparam int CFG_W      = 7;
    localparam int IN_PAGE_W  = 32;
    localparam int SLOT_W     = 6;
    localparam int OUT_PAGE_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic valid;
        logic hit;
        logic free;
    } t_scan_flags;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_commit_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* sv/pcar_cell.sv */
// One slot of the page directory: holds valid, tag and age, and passes the scan word on.
`default_nettype none

module pcar_cell #(
    parameter int SLOTS     = 64,
    parameter int AGE_BITS  = 16,
    parameter int PAGE_BITS = 32,
    parameter int CELL_IDX  = 0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [$clog2(SLOTS+1)-1:0]        i_active_cnt,
    input  wire  pcar_pkg::t_scan_flags       i_tok_ctl,
    input  wire  [PAGE_BITS-1:0]              i_tok_page,
    input  wire  [$clog2(SLOTS)-1:0]          i_tok_hit_idx,
    input  wire  [$clog2(SLOTS)-1:0]          i_tok_free_idx,
    input  wire  [AGE_BITS-1:0]               i_tok_best_age,
    input  wire  [$clog2(SLOTS)-1:0]          i_tok_best_idx,
    input  wire  [PAGE_BITS-1:0]              i_tok_best_tag,
    output pcar_pkg::t_scan_flags             o_tok_ctl,
    output logic [PAGE_BITS-1:0]              o_tok_page,
    output logic [$clog2(SLOTS)-1:0]          o_tok_hit_idx,
    output logic [$clog2(SLOTS)-1:0]          o_tok_free_idx,
    output logic [AGE_BITS-1:0]               o_tok_best_age,
    output logic [$clog2(SLOTS)-1:0]          o_tok_best_idx,
    output logic [PAGE_BITS-1:0]              o_tok_best_tag,
    input  wire  pcar_pkg::t_commit_ctl       i_cmt,
    input  wire  [$clog2(SLOTS)-1:0]          i_cmt_idx,
    input  wire  [PAGE_BITS-1:0]              i_cmt_page
);

    import pcar_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_tag;
    logic [AGE_BITS-1:0]  r_age;

    logic                 r_tok_valid;
    logic                 r_tok_hit;
    logic                 r_tok_free;
    logic [PAGE_BITS-1:0] r_tok_page;
    logic [IDX_W-1:0]     r_tok_hit_idx;
    logic [IDX_W-1:0]     r_tok_free_idx;
    logic [AGE_BITS-1:0]  r_tok_best_age;
    logic [IDX_W-1:0]     r_tok_best_idx;
    logic [PAGE_BITS-1:0] r_tok_best_tag;

    logic                 n_tok_hit;
    logic                 n_tok_free;
    logic [IDX_W-1:0]     n_tok_hit_idx;
    logic [IDX_W-1:0]     n_tok_free_idx;
    logic [AGE_BITS-1:0]  n_tok_best_age;
    logic [IDX_W-1:0]     n_tok_best_idx;
    logic [PAGE_BITS-1:0] n_tok_best_tag;

    logic                 active;
    logic                 mine;
    logic [AGE_BITS-1:0]  age_inc;

    assign active  = i_active_cnt > CNT_W'(CELL_IDX);
    assign mine    = i_cmt_idx == MY_IDX;
    assign age_inc = (&r_age) ? r_age : r_age + AGE_BITS'(1);

    // The scan sees ages as they will be after a miss has aged every slot.
    always_comb begin
        n_tok_hit      = i_tok_ctl.hit;
        n_tok_free     = i_tok_ctl.free;
        n_tok_hit_idx  = i_tok_hit_idx;
        n_tok_free_idx = i_tok_free_idx;
        n_tok_best_age = i_tok_best_age;
        n_tok_best_idx = i_tok_best_idx;
        n_tok_best_tag = i_tok_best_tag;
        if (active) begin
            if (!i_tok_ctl.hit && r_valid && r_tag == i_tok_page) begin
                n_tok_hit     = 1'b1;
                n_tok_hit_idx = MY_IDX;
            end
            if (!i_tok_ctl.free) begin
                if (!r_valid) begin
                    n_tok_free     = 1'b1;
                    n_tok_free_idx = MY_IDX;
                end else if (age_inc > i_tok_best_age) begin
                    n_tok_best_age = age_inc;
                    n_tok_best_idx = MY_IDX;
                    n_tok_best_tag = r_tag;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok_ctl.valid) begin
            r_tok_hit      <= n_tok_hit;
            r_tok_free     <= n_tok_free;
            r_tok_page     <= i_tok_page;
            r_tok_hit_idx  <= n_tok_hit_idx;
            r_tok_free_idx <= n_tok_free_idx;
            r_tok_best_age <= n_tok_best_age;
            r_tok_best_idx <= n_tok_best_idx;
            r_tok_best_tag <= n_tok_best_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
        end else if (i_cmt.valid && active) begin
            if (mine) begin
                r_age <= '0;
                if (!i_cmt.hit) begin
                    r_valid <= 1'b1;
                end
            end else if (!i_cmt.hit) begin
                r_age <= age_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmt.valid && active && mine && !i_cmt.hit) begin
            r_tag <= i_cmt_page;
        end
    end

    assign o_tok_ctl      = '{valid: r_tok_valid, hit: r_tok_hit, free: r_tok_free};
    assign o_tok_page     = r_tok_page;
    assign o_tok_hit_idx  = r_tok_hit_idx;
    assign o_tok_free_idx = r_tok_free_idx;
    assign o_tok_best_age = r_tok_best_age;
    assign o_tok_best_idx = r_tok_best_idx;
    assign o_tok_best_tag = r_tok_best_tag;

endmodule

`default_nettype wire

/* sv/page_cache_age_replacement_unit.sv */
// Top level of the page cache age replacement unit: slot chain, control and result register.
`default_nettype none

// Fully associative page directory with age counters for replacement.
// The input channel takes one page number per word; the output channel returns
// one word per access with hit, the slot now holding the page, and the evicted
// page when a valid slot was replaced. The configuration register sets how
// many slots are active; the user must write it with i_cfg_we only while
// the unit is idle; the block does not enforce this. An accepted word becomes
// a scan word that walks the chain of slot cells, one cell per cycle; a new
// word is accepted only after the previous result has loaded into the output
// register. The slot state is updated in the cycle after the result loads.
// If the receiver stalls, the finished scan waits and no new word is taken
// until the output register is free. Reset frees all slots, clears all ages,
// sets the active count to 64, and takes effect at once with no clearing pass.
module page_cache_age_replacement_unit #(
    parameter int SLOTS     = 64,
    parameter int AGE_BITS  = 16,
    parameter int PAGE_BITS = 32
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [pcar_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire  [pcar_pkg::IN_PAGE_W-1:0]        i_page_number,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_hit,
    output logic [pcar_pkg::SLOT_W-1:0]           o_slot_index,
    output logic                                  o_evicted,
    output logic [pcar_pkg::OUT_PAGE_W-1:0]       o_evicted_page
);

    import pcar_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state                r_state;
    t_state                n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic                  r_tok_valid;
    logic [PAGE_BITS-1:0]  r_tok_page;
    t_commit_ctl           r_cmt;
    logic [IDX_W-1:0]      r_cmt_idx;
    logic [PAGE_BITS-1:0]  r_cmt_page;
    logic                  r_out_valid;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot_index;
    logic                  r_evicted;
    logic [OUT_PAGE_W-1:0] r_evicted_page;

    logic                  in_accept;
    logic                  do_commit;
    logic                  out_free;
    logic                  last_valid;
    logic [CW-1:0]         cfg_ext;
    logic [CNT_W-1:0]      active_cnt;
    logic [IDX_W-1:0]      res_idx;
    logic                  res_evicted;

    t_scan_flags           w_tok_ctl      [0:SLOTS];
    logic [PAGE_BITS-1:0]  w_tok_page     [0:SLOTS];
    logic [IDX_W-1:0]      w_tok_hit_idx  [0:SLOTS];
    logic [IDX_W-1:0]      w_tok_free_idx [0:SLOTS];
    logic [AGE_BITS-1:0]   w_tok_best_age [0:SLOTS];
    logic [IDX_W-1:0]      w_tok_best_idx [0:SLOTS];
    logic [PAGE_BITS-1:0]  w_tok_best_tag [0:SLOTS];

    assign cfg_ext = CW'(r_cfg);

    always_comb begin
        if (cfg_ext == '0) begin
            active_cnt = CNT_W'(1);
        end else if (cfg_ext > CW'(SLOTS)) begin
            active_cnt = CNT_W'(SLOTS);
        end else begin
            active_cnt = CNT_W'(cfg_ext);
        end
    end

    assign w_tok_ctl[0]      = '{valid: r_tok_valid, hit: 1'b0, free: 1'b0};
    assign w_tok_page[0]     = r_tok_page;
    assign w_tok_hit_idx[0]  = '0;
    assign w_tok_free_idx[0] = '0;
    assign w_tok_best_age[0] = '0;
    assign w_tok_best_idx[0] = '0;
    assign w_tok_best_tag[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        pcar_cell #(
            .SLOTS     (SLOTS),
            .AGE_BITS  (AGE_BITS),
            .PAGE_BITS (PAGE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_active_cnt   (active_cnt),
            .i_tok_ctl      (w_tok_ctl[g]),
            .i_tok_page     (w_tok_page[g]),
            .i_tok_hit_idx  (w_tok_hit_idx[g]),
            .i_tok_free_idx (w_tok_free_idx[g]),
            .i_tok_best_age (w_tok_best_age[g]),
            .i_tok_best_idx (w_tok_best_idx[g]),
            .i_tok_best_tag (w_tok_best_tag[g]),
            .o_tok_ctl      (w_tok_ctl[g+1]),
            .o_tok_page     (w_tok_page[g+1]),
            .o_tok_hit_idx  (w_tok_hit_idx[g+1]),
            .o_tok_free_idx (w_tok_free_idx[g+1]),
            .o_tok_best_age (w_tok_best_age[g+1]),
            .o_tok_best_idx (w_tok_best_idx[g+1]),
            .o_tok_best_tag (w_tok_best_tag[g+1]),
            .i_cmt          (r_cmt),
            .i_cmt_idx      (r_cmt_idx),
            .i_cmt_page     (r_cmt_page)
        );
    end

    assign last_valid = w_tok_ctl[SLOTS].valid;
    assign out_free   = !r_out_valid || i_out_ready;

    // The last cell holds its scan word until the next access, so the result is read from it.
    always_comb begin
        res_evicted = !w_tok_ctl[SLOTS].hit && !w_tok_ctl[SLOTS].free;
        if (w_tok_ctl[SLOTS].hit) begin
            res_idx = w_tok_hit_idx[SLOTS];
        end else if (w_tok_ctl[SLOTS].free) begin
            res_idx = w_tok_free_idx[SLOTS];
        end else begin
            res_idx = w_tok_best_idx[SLOTS];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_valid) begin
                    n_state = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        do_commit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_SCAN: begin
                do_commit = last_valid && out_free;
            end
            ST_DONE: begin
                do_commit = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= CFG_RESET;
            r_tok_valid <= 1'b0;
            r_cmt       <= '{valid: 1'b0, hit: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tok_valid <= in_accept;
            r_cmt       <= '{valid: do_commit, hit: w_tok_ctl[SLOTS].hit};
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (do_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tok_page <= PAGE_BITS'(i_page_number);
        end
        if (do_commit) begin
            r_cmt_idx      <= res_idx;
            r_cmt_page     <= w_tok_page[SLOTS];
            r_hit          <= w_tok_ctl[SLOTS].hit;
            r_slot_index   <= SLOT_W'(res_idx);
            r_evicted      <= res_evicted;
            r_evicted_page <= res_evicted ? OUT_PAGE_W'(w_tok_best_tag[SLOTS]) : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_slot_index   = r_slot_index;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;

endmodule

`default_nettype wire

/* tb/page_cache_age_replacement_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the page cache age replacement unit with its own directory predictor.
module page_cache_age_replacement_unit_tb;
    import pcar_pkg::*;

    localparam int SLOTS       = 64;
    localparam int AGE_BITS    = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_WORDS = 160;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_W-1:0]     slot;
        logic                  evicted;
        logic [OUT_PAGE_W-1:0] evicted_page;
    } t_access_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic [IN_PAGE_W-1:0] i_page_number = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_slot_index;
    logic                 o_evicted;
    logic [OUT_PAGE_W-1:0] o_evicted_page;

    logic                 slot_filled [SLOTS];
    logic [IN_PAGE_W-1:0] slot_page [SLOTS];
    logic [AGE_BITS-1:0]  slot_age [SLOTS];
    logic [CFG_W-1:0]     slots_setting = CFG_RESET;

    t_access_result       pending_results[$];
    logic [IN_PAGE_W-1:0] working_set[$];
    t_idle_mode           idle_mode = IDLE_NONE;
    int                   mismatch_count = 0;
    int                   hold_request = 0;
    int                   hold_left = 0;
    int                   cycle_count = 0;

    page_cache_age_replacement_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_page_number  (i_page_number),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_slot_index   (o_slot_index),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("page_cache_age_replacement_unit regression: fail");
            $finish;
        end
    end

    function automatic int active_slots();
        if (slots_setting == 0) begin
            return 1;
        end
        if (slots_setting > SLOTS) begin
            return SLOTS;
        end
        return int'(slots_setting);
    endfunction

    function automatic t_access_result predict_access(input logic [IN_PAGE_W-1:0] page);
        t_access_result res;
        logic [AGE_BITS-1:0] oldest;
        int n;
        int i;
        int pick;
        bit free_found;
        res = '0;
        n = active_slots();
        for (i = 0; i < n; i++) begin
            if (slot_filled[i] && slot_page[i] == page) begin
                slot_age[i] = '0;
                res.hit = 1'b1;
                res.slot = SLOT_W'(i);
                return res;
            end
        end
        for (i = 0; i < n; i++) begin
            if (slot_age[i] != '1) begin
                slot_age[i] = slot_age[i] + 1'b1;
            end
        end
        pick = 0;
        oldest = '0;
        free_found = 1'b0;
        for (i = 0; i < n && !free_found; i++) begin
            if (!slot_filled[i]) begin
                pick = i;
                free_found = 1'b1;
            end else if (slot_age[i] > oldest) begin
                oldest = slot_age[i];
                pick = i;
            end
        end
        if (!free_found && slot_filled[pick]) begin
            res.evicted = 1'b1;
            res.evicted_page = slot_page[pick];
        end
        slot_filled[pick] = 1'b1;
        slot_page[pick] = page;
        slot_age[pick] = '0;
        res.slot = SLOT_W'(pick);
        return res;
    endfunction

    function automatic int sender_gap();
        int pct;
        int gap;
        pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 7 : 0;
        gap = 0;
        if (pct != 0 && $urandom_range(7) == 0) begin
            return $urandom_range(80, 1);
        end
        while ($urandom_range(99) < pct) begin
            gap++;
        end
        return gap;
    endfunction

    task automatic check_word();
        t_access_result want;
        if (pending_results.size() == 0) begin
            $error("result word with no access pending: slot_index %0d", o_slot_index);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            if (o_hit !== want.hit) begin
                $error("hit: expected %0d, actual %0d", want.hit, o_hit);
                mismatch_count++;
            end
            if (o_slot_index !== want.slot) begin
                $error("slot_index: expected %0d, actual %0d", want.slot, o_slot_index);
                mismatch_count++;
            end
            if (o_evicted !== want.evicted) begin
                $error("evicted: expected %0d, actual %0d", want.evicted, o_evicted);
                mismatch_count++;
            end
            if (o_evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %08h, actual %08h",
                       want.evicted_page, o_evicted_page);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_word();
        end
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (idle_mode == IDLE_RECEIVER) begin
            i_out_ready <= ($urandom_range(99) >= 47);
        end else if (idle_mode == IDLE_BOTH) begin
            i_out_ready <= ($urandom_range(99) >= 7);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // The valid line stays high into the next word when no gap follows.
    task automatic send_page(input logic [IN_PAGE_W-1:0] page, input bit last);
        int gap;
        i_in_valid <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_access(page));
        gap = sender_gap();
        if (last && gap == 0) begin
            gap = 1;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_list(input logic [IN_PAGE_W-1:0] pages[$]);
        int k;
        for (k = 0; k < pages.size(); k++) begin
            send_page(pages[k], k == pages.size() - 1);
        end
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The slot state settles in the cycle after the last result loads, so the write waits out a full scan.
    task automatic write_slots(input logic [CFG_W-1:0] value);
        wait_drain();
        repeat (SLOTS + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        slots_setting = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_and_hits();
        idle_mode = IDLE_NONE;
        send_list('{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h8000_0000, 32'h0000_0001});
    endtask

    task automatic test_single_slot();
        write_slots(7'd0);
        send_list('{32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});
        write_slots(7'd1);
        send_list('{32'h0000_0000, 32'h5A5A_5A5A});
    endtask

    task automatic test_inactive_slots();
        write_slots(7'd127);
        send_list('{32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h8000_0000});
        write_slots(7'd2);
        send_list('{32'h0000_0001, 32'h0000_0003, 32'h0000_0004, 32'h0000_0003,
                    32'h0000_0005});
        write_slots(7'd64);
        send_list('{32'h0000_0001, 32'hFFFF_FFFF});
    endtask

    task automatic refresh_working_set(input int size);
        logic [IN_PAGE_W-1:0] kept[$];
        foreach (working_set[k]) begin
            if ($urandom_range(1) == 1) begin
                kept.push_back(working_set[k]);
            end
        end
        working_set = kept;
        while (working_set.size() > size) begin
            void'(working_set.pop_back());
        end
        while (working_set.size() < size) begin
            working_set.push_back($urandom());
        end
    endtask

    function automatic logic [IN_PAGE_W-1:0] random_page();
        int r;
        logic [IN_PAGE_W-1:0] bit_mask;
        r = $urandom_range(99);
        if (r < 80) begin
            return working_set[$urandom_range(working_set.size() - 1)];
        end
        if (r < 90) begin
            return $urandom();
        end
        bit_mask = IN_PAGE_W'(1) << $urandom_range(IN_PAGE_W - 1);
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return bit_mask;
            default: return ~bit_mask;
        endcase
    endfunction

    task automatic test_random_phases();
        logic [CFG_W-1:0] settings [10];
        int ph;
        int k;
        int n;
        settings = '{7'd64, 7'd16, 7'd3, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd0, 7'd64};
        settings[8] = CFG_W'($urandom_range(63, 4));
        for (ph = 0; ph < 10; ph++) begin
            write_slots(settings[ph]);
            idle_mode = t_idle_mode'(ph % 4);
            n = active_slots();
            refresh_working_set(n + $urandom_range(n / 2 + 2, 1));
            for (k = 0; k < PHASE_WORDS; k++) begin
                send_page(random_page(), k == PHASE_WORDS - 1);
            end
        end
    endtask

    task automatic test_backpressure();
        logic [IN_PAGE_W-1:0] burst[$];
        int k;
        write_slots(7'd8);
        idle_mode = IDLE_NONE;
        refresh_working_set(12);
        for (k = 0; k < 12; k++) begin
            burst.push_back(random_page());
        end
        hold_request = 600;
        send_list(burst);
        wait_drain();
        burst.delete();
        for (k = 0; k < 6; k++) begin
            burst.push_back(random_page());
        end
        send_list(burst);
    endtask

    initial begin
        int k;
        for (k = 0; k < SLOTS; k++) begin
            slot_filled[k] = 1'b0;
            slot_page[k] = '0;
            slot_age[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_and_hits();
        test_single_slot();
        test_inactive_slots();
        test_random_phases();
        test_backpressure();
        wait_drain();
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("page_cache_age_replacement_unit regression: pass");
        end else begin
            $display("page_cache_age_replacement_unit regression: fail");
        end
        $finish;
    end
endmodule
